FILE: src/spi_flash_erase_program_sequencer_core_macros.svh
// Assertion macros used by the sequencer back end.
// Each macro expects signals named clock and reset in the enclosing module.
`ifndef SPI_FLASH_ERASE_PROGRAM_SEQUENCER_CORE_MACROS_SVH
`define SPI_FLASH_ERASE_PROGRAM_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SFEPS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SFEPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/sfeps_pkg.sv
// Package for the SPI flash erase/program sequencer.
// Holds sizes, flash opcodes, transaction kinds and the descriptor type; no dependencies.
`timescale 1ns / 1ps

package sfeps_pkg;

   // Flash geometry.
   localparam int unsigned ERASE_SIZE = 4 * 1024;
   localparam int unsigned PAGE_SIZE  = 256;
   localparam int unsigned CHUNK_W    = $clog2(PAGE_SIZE + 1);

   // Field widths.
   localparam int unsigned ADDR_W = 32;
   localparam int unsigned LEN_W  = 26;
   localparam int unsigned OFS_W  = 25;

   // Flash opcodes.
   localparam logic [7:0] OPC_STATUS = 8'h05;
   localparam logic [7:0] OPC_WREN   = 8'h06;
   localparam logic [7:0] OPC_READ3  = 8'h03;
   localparam logic [7:0] OPC_READ4  = 8'h13;
   localparam logic [7:0] OPC_ERASE3 = 8'h20;
   localparam logic [7:0] OPC_ERASE4 = 8'h21;
   localparam logic [7:0] OPC_PROG3  = 8'h02;
   localparam logic [7:0] OPC_PROG4  = 8'h12;

   // Transaction kinds on the result channel.
   localparam logic [1:0] KIND_WRITE_KEEP = 2'd0;
   localparam logic [1:0] KIND_WRITE_END  = 2'd1;
   localparam logic [1:0] KIND_READ_END   = 2'd2;
   localparam logic [1:0] KIND_FINISH     = 2'd3;

   // Operations handed from the front end to the back end.
   localparam logic [2:0] OP_READ       = 3'd0;
   localparam logic [2:0] OP_ERASE      = 3'd1;
   localparam logic [2:0] OP_PROGRAM    = 3'd2;
   localparam logic [2:0] OP_POLL       = 3'd3;
   localparam logic [2:0] OP_FINISH_OK  = 3'd4;
   localparam logic [2:0] OP_FINISH_ERR = 3'd5;

   // One queued operation with everything the back end needs to expand it.
   typedef struct packed {
      logic [2:0]        op;
      logic              four;
      logic [ADDR_W-1:0] addr;
      logic [OFS_W-1:0]  doff;
      logic [LEN_W-1:0]  dlen;
   } sfeps_desc_type;

endpackage

FILE: src/spi_flash_erase_program_sequencer_core.sv
// Channel   Direction  Handshake           Word
// req_      in         push / full         command, address, length, status byte
// rsp_      out        empty / pop         one SPI transaction or a request finish
// csr_      in         valid / ready       four_byte_mode
//
// The front end takes one input word per clock while its two-entry queue has room.
// The back end sends one result word per clock while rsp_ is empty or popped;
// an input gives up to five result words; a full queue raises req_full.
// An input is queued first; its first result word is then registered on rsp_.
// A popped result register refills in that cycle; without rsp_pop the queue fills.
// Reset is synchronous; csr_ready is always high.
//
// Top level of the SPI flash erase/program sequencer.
// Depends on sfeps_pkg, sfeps_front, sfeps_queue and sfeps_back.
`timescale 1ns / 1ps

module spi_flash_erase_program_sequencer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_address,
   input  logic [25:0] req_length,
   input  logic [7:0]  req_status_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_opcode,
   output logic        rsp_has_opcode,
   output logic [31:0] rsp_flash_address,
   output logic [2:0]  rsp_address_length,
   output logic [24:0] rsp_data_offset,
   output logic [25:0] rsp_data_length,
   output logic        rsp_error,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_four_byte_mode
);
   import sfeps_pkg::*;

   logic           accept;
   logic           f_push;
   sfeps_desc_type f_desc;
   logic           q_full;
   logic           q_valid;
   logic           q_pop;
   sfeps_desc_type q_desc;

   // Input words are taken whenever the queue has room.
   assign accept    = req_push && !q_full;
   assign req_full  = q_full;
   assign csr_ready = 1'b1;

   sfeps_front u_front (
      .clock              (clock),
      .reset              (reset),
      .accept             (accept),
      .command            (req_command),
      .address            (req_address),
      .length             (req_length),
      .status_byte        (req_status_byte),
      .csr_valid          (csr_valid),
      .csr_four_byte_mode (csr_four_byte_mode),
      .push               (f_push),
      .desc               (f_desc)
   );

   sfeps_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (f_push),
      .data_in  (f_desc),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .data_out (q_desc)
   );

   sfeps_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .desc               (q_desc),
      .q_pop              (q_pop),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_kind           (rsp_kind),
      .rsp_opcode         (rsp_opcode),
      .rsp_has_opcode     (rsp_has_opcode),
      .rsp_flash_address  (rsp_flash_address),
      .rsp_address_length (rsp_address_length),
      .rsp_data_offset    (rsp_data_offset),
      .rsp_data_length    (rsp_data_length),
      .rsp_error          (rsp_error),
      .rsp_last           (rsp_last)
   );

endmodule

FILE: src/sfeps_front.sv
// Front end: takes request and reply words, tracks the erase/program progress
// and issues one operation descriptor per word that causes flash traffic or ends a request. Uses sfeps_pkg.
`timescale 1ns / 1ps

module sfeps_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [1:0]             command,
   input  logic [31:0]            address,
   input  logic [25:0]            length,
   input  logic [7:0]             status_byte,
   input  logic                   csr_valid,
   input  logic                   csr_four_byte_mode,
   output logic                   push,
   output sfeps_pkg::sfeps_desc_type desc
);
   import sfeps_pkg::*;

   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_ERASE   = 2'd1;
   localparam logic [1:0] PH_PROGRAM = 2'd2;

   localparam logic [1:0] CMD_READ   = 2'd0;
   localparam logic [1:0] CMD_WRITE  = 2'd1;
   localparam logic [1:0] CMD_STATUS = 2'd2;
   localparam logic [1:0] CMD_FAIL   = 2'd3;

   logic [1:0]         phase_ff, phase_in;
   logic               four_ff;
   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [ADDR_W-1:0]  cur_addr_ff, cur_addr_in;
   logic [LEN_W-1:0]   total_ff, total_in;
   logic [LEN_W-1:0]   erase_ofs_ff, erase_ofs_in;
   logic [LEN_W-1:0]   rem_ff, rem_in;
   logic [LEN_W-1:0]   done_ff, done_in;
   logic [CHUNK_W-1:0] chunk_ff, chunk_in;
   logic [LEN_W:0]     eo_sum;
   logic [LEN_W-1:0]   rem_next;

   // Size of the next page program: the remainder, at most one page.
   function automatic logic [CHUNK_W-1:0] chunk_of(input logic [LEN_W-1:0] x);
      logic [CHUNK_W-1:0] r;
      if (x < LEN_W'(PAGE_SIZE)) begin
         r = x[CHUNK_W-1:0];
      end else begin
         r = CHUNK_W'(PAGE_SIZE);
      end
      return r;
   endfunction

   // Next state and the descriptor for the accepted word.
   always_comb begin
      phase_in     = phase_ff;
      base_in      = base_ff;
      cur_addr_in  = cur_addr_ff;
      total_in     = total_ff;
      erase_ofs_in = erase_ofs_ff;
      rem_in       = rem_ff;
      done_in      = done_ff;
      chunk_in     = chunk_ff;
      push         = 1'b0;
      desc.op      = OP_FINISH_OK;
      desc.four    = four_ff;
      desc.addr    = cur_addr_ff;
      desc.doff    = '0;
      desc.dlen    = '0;
      eo_sum       = {1'b0, erase_ofs_ff} + (LEN_W + 1)'(ERASE_SIZE);
      rem_next     = rem_ff - LEN_W'(chunk_ff);
      if (accept) begin
         case (phase_ff)
            PH_IDLE: begin
               if (command == CMD_READ) begin
                  push      = 1'b1;
                  desc.op   = OP_READ;
                  desc.addr = address;
                  desc.dlen = length;
               end else if (command == CMD_WRITE) begin
                  push         = 1'b1;
                  base_in      = address;
                  cur_addr_in  = address;
                  total_in     = length;
                  erase_ofs_in = '0;
                  rem_in       = length;
                  done_in      = '0;
                  chunk_in     = '0;
                  if (length == '0) begin
                     desc.op = OP_FINISH_OK;
                  end else begin
                     desc.op   = OP_ERASE;
                     desc.addr = address;
                     phase_in  = PH_ERASE;
                  end
               end
            end
            PH_ERASE, PH_PROGRAM: begin
               if (command == CMD_FAIL) begin
                  push     = 1'b1;
                  desc.op  = OP_FINISH_ERR;
                  phase_in = PH_IDLE;
               end else if (command == CMD_STATUS) begin
                  push = 1'b1;
                  if (status_byte[1:0] != 2'b00) begin
                     // Busy or write-enable still set: poll again.
                     desc.op = OP_POLL;
                  end else if (phase_ff == PH_ERASE) begin
                     erase_ofs_in = eo_sum[LEN_W-1:0];
                     if (eo_sum < {1'b0, total_ff}) begin
                        cur_addr_in = cur_addr_ff + ADDR_W'(ERASE_SIZE);
                        desc.op     = OP_ERASE;
                        desc.addr   = cur_addr_in;
                     end else begin
                        // Erase done: program the first page.
                        rem_in      = total_ff;
                        done_in     = '0;
                        chunk_in    = chunk_of(total_ff);
                        cur_addr_in = base_ff;
                        desc.op     = OP_PROGRAM;
                        desc.addr   = base_ff;
                        desc.dlen   = LEN_W'(chunk_in);
                        phase_in    = PH_PROGRAM;
                     end
                  end else begin
                     rem_in = rem_next;
                     if (rem_next == '0) begin
                        desc.op  = OP_FINISH_OK;
                        phase_in = PH_IDLE;
                     end else begin
                        done_in     = done_ff + LEN_W'(chunk_ff);
                        cur_addr_in = cur_addr_ff + ADDR_W'(chunk_ff);
                        chunk_in    = chunk_of(rem_next);
                        desc.op     = OP_PROGRAM;
                        desc.addr   = cur_addr_in;
                        desc.doff   = done_in[OFS_W-1:0];
                        desc.dlen   = LEN_W'(chunk_in);
                     end
                  end
               end
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // Control state and the mode register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         four_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (csr_valid) begin
            four_ff <= csr_four_byte_mode;
         end
      end
   end

   // Progress registers, loaded at the start of every write request and advanced by its status replies.
   always_ff @(posedge clock) begin
      base_ff      <= base_in;
      cur_addr_ff  <= cur_addr_in;
      total_ff     <= total_in;
      erase_ofs_ff <= erase_ofs_in;
      rem_ff       <= rem_in;
      done_ff      <= done_in;
      chunk_ff     <= chunk_in;
   end

endmodule

FILE: src/sfeps_queue.sv
// Two-entry descriptor queue between the front end and the back end.
// Uses sfeps_pkg for the descriptor type.
`timescale 1ns / 1ps

module sfeps_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  sfeps_pkg::sfeps_desc_type data_in,
   output logic                      full,
   input  logic                      pop,
   output logic                      valid,
   output sfeps_pkg::sfeps_desc_type data_out
);
   import sfeps_pkg::*;

   sfeps_desc_type entries_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;
   logic           do_push, do_pop;

   // Pointer and occupancy updates.
   always_comb begin
      do_push   = push && !full;
      do_pop    = pop && valid;
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   assign full     = (count_ff == 2'd2);
   assign valid    = (count_ff != 2'd0);
   assign data_out = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= data_in;
      end
   end

endmodule

FILE: src/sfeps_back.sv
// Back end: expands each queued operation into its SPI transaction words, one word per
// cycle into the result register while it is empty or popped. Uses sfeps_pkg and the macro header.
`timescale 1ns / 1ps
`include "spi_flash_erase_program_sequencer_core_macros.svh"

module sfeps_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   input  sfeps_pkg::sfeps_desc_type desc,
   output logic                      q_pop,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [1:0]                rsp_kind,
   output logic [7:0]                rsp_opcode,
   output logic                      rsp_has_opcode,
   output logic [31:0]               rsp_flash_address,
   output logic [2:0]                rsp_address_length,
   output logic [24:0]               rsp_data_offset,
   output logic [25:0]               rsp_data_length,
   output logic                      rsp_error,
   output logic                      rsp_last
);
   import sfeps_pkg::*;

   localparam logic [2:0] W_WREN      = 3'd0;
   localparam logic [2:0] W_CMD       = 3'd1;
   localparam logic [2:0] W_DATA_WR   = 3'd2;
   localparam logic [2:0] W_STATUS    = 3'd3;
   localparam logic [2:0] W_STATUS_RD = 3'd4;
   localparam logic [2:0] W_DATA_RD   = 3'd5;
   localparam logic [2:0] W_FINISH    = 3'd6;

   localparam logic [2:0] ALEN_3 = 3'd3;
   localparam logic [2:0] ALEN_4 = 3'd4;

   logic [2:0]        step_ff, step_in;
   logic [2:0]        last_step;
   logic [2:0]        word_code;
   logic              word_last;
   logic              load;
   logic              valid_ff, valid_in;
   logic [1:0]        w_kind;
   logic [7:0]        w_opcode;
   logic              w_has_opcode;
   logic [ADDR_W-1:0] w_addr;
   logic [2:0]        w_alen;
   logic [OFS_W-1:0]  w_doff;
   logic [LEN_W-1:0]  w_dlen;
   logic              w_error;

   // Which word of the operation goes out at this step.
   always_comb begin
      last_step = 3'd0;
      word_code = W_FINISH;
      case (desc.op)
         OP_READ: begin
            last_step = 3'd2;
            case (step_ff)
               3'd0:    word_code = W_CMD;
               3'd1:    word_code = W_DATA_RD;
               default: word_code = W_FINISH;
            endcase
         end
         OP_ERASE: begin
            last_step = 3'd3;
            case (step_ff)
               3'd0:    word_code = W_WREN;
               3'd1:    word_code = W_CMD;
               3'd2:    word_code = W_STATUS;
               default: word_code = W_STATUS_RD;
            endcase
         end
         OP_PROGRAM: begin
            last_step = 3'd4;
            case (step_ff)
               3'd0:    word_code = W_WREN;
               3'd1:    word_code = W_CMD;
               3'd2:    word_code = W_DATA_WR;
               3'd3:    word_code = W_STATUS;
               default: word_code = W_STATUS_RD;
            endcase
         end
         OP_POLL: begin
            last_step = 3'd1;
            word_code = (step_ff == 3'd0) ? W_STATUS : W_STATUS_RD;
         end
         default: begin
            last_step = 3'd0;
            word_code = W_FINISH;
         end
      endcase
      word_last = (step_ff == last_step);
   end

   // Fields of the word being built.
   always_comb begin
      w_kind       = KIND_WRITE_KEEP;
      w_opcode     = 8'h00;
      w_has_opcode = 1'b0;
      w_addr       = '0;
      w_alen       = 3'd0;
      w_doff       = '0;
      w_dlen       = '0;
      w_error      = 1'b0;
      case (word_code)
         W_WREN: begin
            w_kind       = KIND_WRITE_END;
            w_opcode     = OPC_WREN;
            w_has_opcode = 1'b1;
         end
         W_CMD: begin
            w_kind       = (desc.op == OP_ERASE) ? KIND_WRITE_END : KIND_WRITE_KEEP;
            w_has_opcode = 1'b1;
            case (desc.op)
               OP_READ:  w_opcode = desc.four ? OPC_READ4 : OPC_READ3;
               OP_ERASE: w_opcode = desc.four ? OPC_ERASE4 : OPC_ERASE3;
               default:  w_opcode = desc.four ? OPC_PROG4 : OPC_PROG3;
            endcase
            w_addr = desc.four ? desc.addr : {8'h00, desc.addr[23:0]};
            w_alen = desc.four ? ALEN_4 : ALEN_3;
         end
         W_DATA_WR: begin
            w_kind = KIND_WRITE_END;
            w_doff = desc.doff;
            w_dlen = desc.dlen;
         end
         W_STATUS: begin
            w_kind       = KIND_WRITE_KEEP;
            w_opcode     = OPC_STATUS;
            w_has_opcode = 1'b1;
         end
         W_STATUS_RD: begin
            w_kind = KIND_READ_END;
            w_dlen = LEN_W'(1);
         end
         W_DATA_RD: begin
            w_kind = KIND_READ_END;
            w_dlen = desc.dlen;
         end
         W_FINISH: begin
            w_kind  = KIND_FINISH;
            w_error = (desc.op == OP_FINISH_ERR);
         end
         default: begin
            w_kind = KIND_WRITE_KEEP;
         end
      endcase
   end

   // Step counter and result register handshake.
   always_comb begin
      load     = q_valid && (!valid_ff || rsp_pop);
      q_pop    = load && word_last;
      valid_in = load || (valid_ff && !rsp_pop);
      step_in  = step_ff;
      if (load) begin
         step_in = word_last ? 3'd0 : step_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   // Result word register.
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_kind           <= w_kind;
         rsp_opcode         <= w_opcode;
         rsp_has_opcode     <= w_has_opcode;
         rsp_flash_address  <= w_addr;
         rsp_address_length <= w_alen;
         rsp_data_offset    <= w_doff;
         rsp_data_length    <= w_dlen;
         rsp_error          <= w_error;
         rsp_last           <= word_last;
      end
   end

   assign rsp_empty = !valid_ff;

   // Checks on the expansion sequencer.
   `SFEPS_ASSERT_IMP(a_step_idle, !q_valid, step_ff == 3'd0, "step moved with no operation")
   `SFEPS_ASSERT_IMP(a_step_range, q_valid, step_ff <= last_step, "step past the last word")
   `SFEPS_ASSERT_IMP(a_finish_last, load && (w_kind == KIND_FINISH), word_last,
      "finish word is not the last word")
   `SFEPS_ASSERT_NEXT(a_pop_rewinds, q_pop, step_ff == 3'd0, "step not rewound after pop")

endmodule
